[hdl/qesm_pkg.sv]
// qesm_pkg: shared types and constants for the quadrature encoder speed meter.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package qesm_pkg;

  localparam int CNT_W   = 16;
  localparam int TICK_W  = 17;
  localparam int QUO_W   = 21;
  localparam int SPD_W   = 22;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int STEP_W  = 5;

  localparam logic [IDX_W-1:0] REG_RELOAD   = 2'd0;
  localparam logic [IDX_W-1:0] REG_X4       = 2'd1;
  localparam logic [IDX_W-1:0] REG_PPR      = 2'd2;
  localparam logic [IDX_W-1:0] REG_INTERVAL = 2'd3;

  localparam logic [CNT_W-1:0]  RELOAD_RST   = 16'hFFFF;
  localparam logic              X4_RST       = 1'b1;
  localparam logic [CNT_W-1:0]  PPR_RST      = 16'd1000;
  localparam logic [CNT_W-1:0]  INTERVAL_RST = 16'd1000;

  localparam logic [CNT_W-1:0]  SMALL_MOVE_LIMIT = 16'd100;
  localparam logic [TICK_W-1:0] TICKS_MAX        = 17'h1FFFF;
  localparam logic [STEP_W-1:0] DIV_LAST_STEP    = 5'(QUO_W - 1);

  typedef struct packed {
    logic accept;
    logic prep;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic measure;
    logic div_done;
  } sts_t;

endpackage

[hdl/quadrature_encoder_speed_meter_core.sv]
// quadrature_encoder_speed_meter_core: top level of the encoder speed meter.
// Depends on qesm_pkg, qesm_ctrl and qesm_dp.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one request per millisecond tick (encoder count and count-down flag).
//   out_* : one result per measurement: count difference, direction, signed speed.
//   cfg_* : register writes (reload, x4 mode, pulses per rotation, sample interval),
//           taken in the cycle cfg_we is high; write only while idle.
// Timing:
//   A tick that does not measure leaves in_ready high, so such ticks run back to back.
//   A measuring tick: the accepting cycle captures the difference, S_PREP forms the
//   dividend, S_DIV runs the restoring divider (one quotient bit per cycle), S_HOLD
//   loads the output register once it is free. out_valid rises as the result is
//   loaded; in_ready is low from the accept until then, so no new request is taken
//   while a measurement is under way.
// Stall:
//   The result sits in the output register until taken; a new request is accepted
//   meanwhile, and a further result waits in the datapath until the register frees.
// Reset:
//   Synchronous, active low; registers return to defaults, tick count and
//   previous count clear, no result is pending.

module quadrature_encoder_speed_meter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [qesm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [qesm_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [qesm_pkg::CNT_W-1:0]        in_counter_value,
  input  logic                              in_counting_down,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [qesm_pkg::CNT_W-1:0]        out_count_difference,
  output logic                              out_direction,
  output logic signed [qesm_pkg::SPD_W-1:0] out_signed_speed
);
  import qesm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qesm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qesm_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_counter_value     (in_counter_value),
    .in_counting_down     (in_counting_down),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_count_difference (out_count_difference),
    .out_direction        (out_direction),
    .out_signed_speed     (out_signed_speed)
  );

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready)
    else $error("request accepted during divide");

  a_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result valid without output load");

  a_down_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_direction) |-> !out_signed_speed[SPD_W-1])
    else $error("down direction with negative speed");

  a_up_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_direction) |->
      (out_signed_speed[SPD_W-1] || (out_signed_speed == '0)))
    else $error("up direction with positive speed");

endmodule

[hdl/qesm_ctrl.sv]
// qesm_ctrl: request sequencing for the speed meter (accept, prepare, divide, output).
// Depends on qesm_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module qesm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  qesm_pkg::sts_t sts,
  output qesm_pkg::cmd_t cmd
);
  import qesm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept   = in_valid && in_ready_r;
    cmd.prep     = (state_r == S_PREP);
    cmd.step     = (state_r == S_DIV);
    cmd.load_out = (state_r == S_HOLD) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.accept && sts.measure) state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  if (sts.div_done) state_nxt = S_HOLD;
      S_HOLD: if (cmd.load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

[hdl/qesm_dp.sv]
// qesm_dp: registers, tick counter, direction/difference logic and serial divider.
// Depends on qesm_pkg; sequenced by qesm_ctrl through cmd_t.
`timescale 1ns / 1ps

module qesm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [qesm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [qesm_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [qesm_pkg::CNT_W-1:0]    in_counter_value,
  input  logic                          in_counting_down,
  input  qesm_pkg::cmd_t                cmd,
  output qesm_pkg::sts_t                sts,
  output logic [qesm_pkg::CNT_W-1:0]    out_count_difference,
  output logic                          out_direction,
  output logic signed [qesm_pkg::SPD_W-1:0] out_signed_speed
);
  import qesm_pkg::*;

  logic [CNT_W-1:0]  reload_r;
  logic              x4_r;
  logic [CNT_W-1:0]  ppr_r;
  logic [CNT_W-1:0]  interval_r;

  logic [CNT_W-1:0]  prev_r;
  logic [TICK_W-1:0] ticks_r;
  logic [TICK_W-1:0] ticks_inc;

  logic [CNT_W-1:0]  diff_r;
  logic              dir_r;
  logic [CNT_W-1:0]  divisor_r;
  logic [CNT_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;

  logic [CNT_W-1:0]  out_diff_r;
  logic              out_dir_r;
  logic [SPD_W-1:0]  out_speed_r;

  logic [CNT_W-1:0]  up_d, dn_d, opa, opb, base, diff_c;
  logic              dir_c;
  logic [QUO_W-1:0]  diff_ext, prod15, prod;
  logic [CNT_W:0]    trial, trial_sub;
  logic              ge;
  logic [SPD_W-1:0]  speed_ext;

  assign ticks_inc   = (ticks_r == TICKS_MAX) ? ticks_r : ticks_r + 17'd1;
  assign sts.measure = ticks_inc > {1'b0, interval_r};

  always_comb begin
    up_d = in_counter_value - prev_r;
    dn_d = prev_r - in_counter_value;
    if (in_counting_down)
      dir_c = !((in_counter_value > prev_r) && (up_d < SMALL_MOVE_LIMIT));
    else
      dir_c = (prev_r > in_counter_value) && (dn_d < SMALL_MOVE_LIMIT);
    opa    = dir_c ? prev_r : in_counter_value;
    opb    = dir_c ? in_counter_value : prev_r;
    base   = opa - opb;
    diff_c = (opa < opb) ? base + reload_r : base;
  end

  // diff*60/4 = diff*15, diff*60/2 = diff*30
  assign diff_ext = {5'd0, diff_r};
  assign prod15   = (diff_ext << 4) - diff_ext;
  assign prod     = x4_r ? prod15 : {prod15[QUO_W-2:0], 1'b0};

  assign trial     = {rem_r, quo_r[QUO_W-1]};
  assign ge        = trial >= {1'b0, divisor_r};
  assign trial_sub = trial - {1'b0, divisor_r};
  assign sts.div_done = cmd.step && (step_r == DIV_LAST_STEP);

  assign speed_ext = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r   <= RELOAD_RST;
      x4_r       <= X4_RST;
      ppr_r      <= PPR_RST;
      interval_r <= INTERVAL_RST;
      prev_r     <= '0;
      ticks_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RELOAD:   reload_r   <= cfg_wdata;
          REG_X4:       x4_r       <= cfg_wdata[0];
          REG_PPR:      ppr_r      <= cfg_wdata;
          REG_INTERVAL: interval_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (sts.measure) begin
          ticks_r <= '0;
          prev_r  <= in_counter_value;
        end else begin
          ticks_r <= ticks_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.measure) begin
      diff_r <= diff_c;
      dir_r  <= dir_c;
    end
    if (cmd.prep) begin
      rem_r     <= '0;
      quo_r     <= prod;
      divisor_r <= (ppr_r == '0) ? 16'd1 : ppr_r;
      step_r    <= '0;
    end
    if (cmd.step) begin
      rem_r  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r  <= {quo_r[QUO_W-2:0], ge};
      step_r <= step_r + 5'd1;
    end
    if (cmd.load_out) begin
      out_diff_r  <= diff_r;
      out_dir_r   <= dir_r;
      out_speed_r <= dir_r ? speed_ext : (~speed_ext + 22'd1);
    end
  end

  assign out_count_difference = out_diff_r;
  assign out_direction        = out_dir_r;
  assign out_signed_speed     = out_speed_r;

endmodule

[tb/sv/tb_quadrature_encoder_speed_meter_core.sv]
// Testbench for quadrature_encoder_speed_meter_core: directed and random encoder ticks,
// with speed results predicted in the bench and checked in order of arrival.
// Depends on qesm_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_quadrature_encoder_speed_meter_core;
  import qesm_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]        diff;
    logic                    dir;
    logic signed [SPD_W-1:0] speed;
  } speed_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = REG_RELOAD;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CNT_W-1:0]        in_counter_value = '0;
  logic                    in_counting_down = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CNT_W-1:0]        out_count_difference;
  logic                    out_direction;
  logic signed [SPD_W-1:0] out_signed_speed;

  // bench copy of the block's registers and state
  logic [CNT_W-1:0]  reload_reg = RELOAD_RST;
  logic              x4_reg = X4_RST;
  logic [CNT_W-1:0]  ppr_reg = PPR_RST;
  logic [CNT_W-1:0]  interval_reg = INTERVAL_RST;
  logic [CNT_W-1:0]  prev_count = '0;
  logic [TICK_W-1:0] tick_count = '0;

  speed_result_t speed_results_due[$];
  speed_result_t due_r;

  int error_count = 0;
  int results_checked = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int stall_len_max = 0;
  int stall_left = 0;
  int drain_wait;

  quadrature_encoder_speed_meter_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_counter_value     (in_counter_value),
    .in_counting_down     (in_counting_down),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_count_difference (out_count_difference),
    .out_direction        (out_direction),
    .out_signed_speed     (out_signed_speed)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Timeout: %0d speed results still due", speed_results_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // One tick of the speed meter; returns 1 when the tick takes a measurement.
  function automatic bit predict_speed_sample(input logic [CNT_W-1:0] cnt, input logic down,
                                              output speed_result_t res);
    logic [CNT_W-1:0] prev;
    logic             dir;
    logic [CNT_W-1:0] diff;
    logic [31:0]      divisor;
    logic [31:0]      spd;
    logic [31:0]      sspd;
    res = '0;
    prev = prev_count;
    if (tick_count != TICKS_MAX) tick_count = tick_count + 1'b1;
    if (tick_count <= {1'b0, interval_reg}) return 1'b0;
    if (down) begin
      dir = 1'b1;
      if (cnt > prev && (cnt - prev) < SMALL_MOVE_LIMIT) dir = 1'b0;
    end else begin
      dir = 1'b0;
      if (prev > cnt && (prev - cnt) < SMALL_MOVE_LIMIT) dir = 1'b1;
    end
    if (dir) begin
      if (prev >= cnt) diff = prev - cnt;
      else diff = 16'(32'(reload_reg) + 32'(prev) - 32'(cnt));
    end else begin
      if (cnt >= prev) diff = cnt - prev;
      else diff = 16'(32'(reload_reg) + 32'(cnt) - 32'(prev));
    end
    divisor = (ppr_reg == '0) ? 32'd1 : 32'(ppr_reg);
    spd = (32'(diff) * 32'd60 / (x4_reg ? 32'd4 : 32'd2)) / divisor;
    sspd = dir ? spd : (32'd0 - spd);
    tick_count = '0;
    prev_count = cnt;
    res.diff = diff;
    res.dir = dir;
    res.speed = sspd[SPD_W-1:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, stall_len_max);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (speed_results_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t unexpected result: diff %0d dir %0d speed %0d", $realtime,
                   out_count_difference, out_direction, out_signed_speed);
      end else begin
        due_r = speed_results_due.pop_front();
        results_checked++;
        if (out_count_difference !== due_r.diff || out_direction !== due_r.dir ||
            out_signed_speed !== due_r.speed) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t mismatch: exp diff %0d dir %0d speed %0d, got diff %0d dir %0d speed %0d",
                     $realtime, due_r.diff, due_r.dir, due_r.speed, out_count_difference,
                     out_direction, out_signed_speed);
        end
      end
    end
  end

  task automatic send_tick(input logic [CNT_W-1:0] cnt, input logic down);
    int            gap;
    speed_result_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) gap = $urandom_range(0, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_counter_value <= cnt;
    in_counting_down <= down;
    do @(posedge clk); while (!in_ready);
    if (predict_speed_sample(cnt, down, res)) speed_results_due.push_back(res);
    ticks_sent++;
  endtask

  // hold off requests until every result is out and the block has settled
  task automatic wait_drained;
    in_valid <= 1'b0;
    while (speed_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] reload, input logic x4,
                           input logic [CNT_W-1:0] ppr, input logic [CNT_W-1:0] interval);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_RELOAD;
    cfg_wdata <= reload;
    @(posedge clk);
    cfg_index <= REG_X4;
    cfg_wdata <= CFG_W'(x4);
    @(posedge clk);
    cfg_index <= REG_PPR;
    cfg_wdata <= ppr;
    @(posedge clk);
    cfg_index <= REG_INTERVAL;
    cfg_wdata <= interval;
    @(posedge clk);
    cfg_we <= 1'b0;
    reload_reg = reload;
    x4_reg = x4;
    ppr_reg = ppr;
    interval_reg = interval;
    settings_used++;
  endtask

  task automatic test_reset_defaults;
    send_tick(16'd1234, 1'b0);
    send_tick(16'd4321, 1'b1);
  endtask

  task automatic test_direction_and_wrap;
    configure(16'hFFFF, 1'b1, 16'd1, 16'd0);
    send_tick(16'd0, 1'b0);
    send_tick(16'd50, 1'b1);
    send_tick(16'd0, 1'b0);
    send_tick(16'd100, 1'b1);
    send_tick(16'd1, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd0, 1'b0);
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'hFFFF, 1'b1);
  endtask

  task automatic test_speed_extremes;
    configure(16'd0, 1'b0, 16'd0, 16'd0);
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd100, 1'b0);
    send_tick(16'd200, 1'b1);
    send_tick(16'h5555, 1'b1);
    send_tick(16'hAAAA, 1'b0);
  endtask

  task automatic test_long_interval;
    configure(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    send_tick(16'd10, 1'b0);
    send_tick(16'd20, 1'b0);
    send_tick(16'd30, 1'b1);
  endtask

  task automatic run_motion(input int n_items);
    int               span;
    int               pos;
    int               step;
    int               r;
    int               i;
    logic             down;
    logic             flag;
    logic [CNT_W-1:0] cnt;
    span = (reload_reg == '0) ? 65536 : int'(reload_reg) + 1;
    pos = $urandom_range(0, span - 1);
    down = 1'($urandom_range(0, 1));
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 8) down = ~down;
      case ($urandom_range(0, 3))
        0: step = $urandom_range(0, 99);
        1: step = $urandom_range(100, 999);
        2: step = $urandom_range(0, span - 1);
        default: step = $urandom_range(0, 3);
      endcase
      step = step % span;
      if (down) pos = (pos - step + span) % span;
      else pos = (pos + step) % span;
      cnt = 16'(pos);
      flag = down;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        cnt = 16'($urandom);
        flag = 1'($urandom_range(0, 1));
      end else if (r < 15) begin
        flag = ~flag;
      end
      send_tick(cnt, flag);
    end
  endtask

  task automatic test_random_motion;
    int               phase;
    logic [CNT_W-1:0] reload;
    logic             x4;
    logic [CNT_W-1:0] ppr;
    logic [CNT_W-1:0] interval;
    for (phase = 0; phase < 8; phase++) begin
      x4 = 1'($urandom_range(0, 1));
      interval = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(6, 40))
                                             : 16'($urandom_range(0, 5));
      case ($urandom_range(0, 2))
        0: reload = 16'hFFFF;
        1: reload = 16'($urandom);
        default: reload = 16'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 2))
        0: ppr = 16'($urandom_range(1, 8));
        1: ppr = 16'($urandom);
        default: ppr = 16'hFFFF;
      endcase
      case (phase)
        0: begin
          reload = 16'hFFFF;
          x4 = 1'b1;
          ppr = 16'd1;
          interval = 16'd0;
        end
        1: begin
          reload = 16'd0;
          x4 = 1'b0;
          ppr = 16'd3;
          interval = 16'd2;
        end
        2: ppr = 16'd0;
        default: ;
      endcase
      configure(reload, x4, ppr, interval);
      if (phase == 0) begin
        gap_max = 0;
        stall_pct = 0;
      end else begin
        gap_max = $urandom_range(0, 6);
        stall_pct = $urandom_range(0, 30);
        stall_len_max = $urandom_range(1, 30);
      end
      run_motion(105);
    end
    gap_max = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_direction_and_wrap();
    test_speed_extremes();
    test_long_interval();
    test_random_motion();
    in_valid <= 1'b0;
    drain_wait = 0;
    while (speed_results_due.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (60) @(posedge clk);
    if (speed_results_due.size() != 0) begin
      $display("%0d speed results never arrived", speed_results_due.size());
      error_count += speed_results_due.size();
    end
    $display("Sent %0d encoder ticks under %0d register settings; %0d speed results checked",
             ticks_sent, settings_used, results_checked);
    $display("Failures: %0d", error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
